>>> src/sbt_pkg.sv
`default_nettype none

package sbt_pkg;

   localparam int SBT_DEPTH = 16;
   localparam int SEG_W     = 32;
   localparam int TIME_W    = 48;

   typedef logic signed [SEG_W-1:0]  seg_type;
   typedef logic signed [TIME_W-1:0] time_type;

   localparam time_type MARK_RESET = {1'b1, {(TIME_W-1){1'b0}}};

   typedef enum logic [2:0] {
      OP_PUBLISH     = 3'd0,
      OP_RAISE_MARK  = 3'd1,
      OP_EXACT       = 3'd2,
      OP_AFTER_NUM   = 3'd3,
      OP_AFTER_TIME  = 3'd4,
      OP_AT_OR_BEF   = 3'd5,
      OP_ANCHOR      = 3'd6
   } opcode_type;

   typedef struct packed {
      seg_type  seg;
      time_type stamp;
      logic     opening;
   } entry_type;

   // A lookup request traveling down the chain, newest cell first.
   // Side a keeps the first (newest) at-or-before match, side b the last
   // (oldest) match of the forward search.
   typedef struct packed {
      logic       valid;
      opcode_type op;
      seg_type    key_seg;
      time_type   key_time;
      logic       a_hit;
      entry_type  a;
      logic       b_hit;
      entry_type  b;
   } token_type;

endpackage

`default_nettype wire

>>> src/segment_boundary_table_core.sv
`default_nettype none

// Segment boundary table: a bounded, time-ordered list of boundaries
// (number, end time, opening flag) plus a high-water mark.
// A request is taken at a clock edge where start is high and busy is low.
// Every request gives exactly one result, shown on the rsp_ ports for one
// cycle with rsp_strobe high; the receiver cannot stall, so results are
// never held back.
// Publish, raise-mark and unused opcodes finish at once: the result appears
// in the cycle after the request and busy stays low, so one such request
// can be taken every cycle while no lookup holds the block busy.
// Lookups and anchor derivation walk a query down the row of DEPTH cells,
// one cell per cycle from newest to oldest; the result is registered once
// the query leaves the last cell and appears in the first cycle with busy
// low again. Busy stays high while the query is in the cell row, so the
// block takes no request meanwhile. The length of the cell row sets this.
// Reset empties the table and sets the mark to the most negative time;
// cell contents are not cleared and are read only after being written.
module segment_boundary_table_core
   import sbt_pkg::*;
#(
   parameter int DEPTH = SBT_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output      logic              busy,
   input  wire logic [2:0]        req_opcode,
   input  wire logic [SEG_W-1:0]  req_seg_in,
   input  wire logic [TIME_W-1:0] req_time_in,
   input  wire logic              req_opening_in,
   output      logic              rsp_strobe,
   output      logic              rsp_found,
   output      logic [SEG_W-1:0]  rsp_seg_out,
   output      logic [TIME_W-1:0] rsp_time_out,
   output      logic              rsp_opening_out,
   output      logic              rsp_dropped,
   output      logic [TIME_W-1:0] rsp_mark_out,
   output      logic              rsp_table_nonempty
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   opcode_type       op;
   logic             accept;
   logic             is_lookup;
   logic             drop;
   logic             do_publish;
   entry_type        new_entry;
   token_type        head_tok;
   token_type        tail_tok;
   entry_type        ent_chain [DEPTH];
   token_type        tok_chain [DEPTH];
   logic [DEPTH-1:0] tok_valid;

   logic [CNT_W-1:0] count_ff, count_in;
   time_type         mark_ff, mark_in;
   logic             busy_ff, busy_in;

   logic             rsp_strobe_ff, rsp_strobe_in;
   logic             rsp_found_ff, rsp_found_in;
   seg_type          rsp_seg_ff, rsp_seg_in;
   time_type         rsp_time_ff, rsp_time_in;
   logic             rsp_open_ff, rsp_open_in;
   logic             rsp_drop_ff, rsp_drop_in;
   time_type         rsp_mark_ff, rsp_mark_in;
   logic             rsp_nonempty_ff, rsp_nonempty_in;

   assign op        = opcode_type'(req_opcode);
   assign accept    = start && !busy_ff;
   assign is_lookup = op inside {OP_EXACT, OP_AFTER_NUM, OP_AFTER_TIME, OP_AT_OR_BEF,
                                 OP_ANCHOR};

   // The newest boundary always sits in the first cell.
   assign drop = (count_ff != '0) &&
                 (($signed(req_seg_in) <= $signed(ent_chain[0].seg)) ||
                  ($signed(req_time_in) < $signed(ent_chain[0].stamp)));
   assign do_publish = accept && (op == OP_PUBLISH) && !drop;

   assign new_entry.seg     = req_seg_in;
   assign new_entry.stamp   = req_time_in;
   assign new_entry.opening = req_opening_in;

   always_comb begin
      head_tok          = '0;
      head_tok.valid    = accept && is_lookup;
      head_tok.op       = op;
      head_tok.key_seg  = req_seg_in;
      head_tok.key_time = req_time_in;
   end

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         sbt_cell #(.DEPTH(DEPTH), .IDX(k)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift_i (do_publish),
            .entry_i (new_entry),
            .entry_o (ent_chain[k]),
            .count_i (count_ff),
            .tok_i   (head_tok),
            .tok_o   (tok_chain[k])
         );
      end else begin : g_body
         sbt_cell #(.DEPTH(DEPTH), .IDX(k)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift_i (do_publish),
            .entry_i (ent_chain[k-1]),
            .entry_o (ent_chain[k]),
            .count_i (count_ff),
            .tok_i   (tok_chain[k-1]),
            .tok_o   (tok_chain[k])
         );
      end
      assign tok_valid[k] = tok_chain[k].valid;
   end

   assign tail_tok = tok_chain[DEPTH-1];

   always_comb begin
      count_in = count_ff;
      if (do_publish && (count_ff != CNT_W'(DEPTH))) begin
         count_in = count_ff + CNT_W'(1);
      end

      mark_in = mark_ff;
      if ((do_publish || (accept && op == OP_RAISE_MARK)) &&
          ($signed(req_time_in) > $signed(mark_ff))) begin
         mark_in = req_time_in;
      end

      busy_in = busy_ff;
      if (accept && is_lookup) begin
         busy_in = 1'b1;
      end else if (tail_tok.valid) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_strobe_in   = 1'b0;
      rsp_found_in    = 1'b0;
      rsp_seg_in      = '0;
      rsp_time_in     = '0;
      rsp_open_in     = 1'b0;
      rsp_drop_in     = 1'b0;
      rsp_mark_in     = mark_in;
      rsp_nonempty_in = count_in != '0;
      if (accept && !is_lookup) begin
         rsp_strobe_in = 1'b1;
         rsp_drop_in   = (op == OP_PUBLISH) && drop;
      end else if (tail_tok.valid) begin
         rsp_strobe_in = 1'b1;
         case (tail_tok.op)
            OP_AT_OR_BEF: begin
               rsp_found_in = tail_tok.a_hit;
               if (tail_tok.a_hit) begin
                  rsp_seg_in  = tail_tok.a.seg;
                  rsp_time_in = tail_tok.a.stamp;
                  rsp_open_in = tail_tok.a.opening;
               end
            end
            OP_ANCHOR: begin
               if (tail_tok.a_hit) begin
                  rsp_found_in = 1'b1;
                  rsp_seg_in   = tail_tok.a.seg;
                  rsp_time_in  = tail_tok.a.stamp;
                  rsp_open_in  = tail_tok.a.opening;
               end else if (tail_tok.b_hit) begin
                  // A non-opening boundary anchors the segment before it.
                  rsp_found_in = 1'b1;
                  rsp_seg_in   = tail_tok.b.seg - SEG_W'(!tail_tok.b.opening);
                  rsp_time_in  = tail_tok.b.stamp;
                  rsp_open_in  = tail_tok.b.opening;
               end
            end
            default: begin
               rsp_found_in = tail_tok.b_hit;
               if (tail_tok.b_hit) begin
                  rsp_seg_in  = tail_tok.b.seg;
                  rsp_time_in = tail_tok.b.stamp;
                  rsp_open_in = tail_tok.b.opening;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         mark_ff       <= MARK_RESET;
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         mark_ff       <= mark_in;
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff    <= rsp_found_in;
      rsp_seg_ff      <= rsp_seg_in;
      rsp_time_ff     <= rsp_time_in;
      rsp_open_ff     <= rsp_open_in;
      rsp_drop_ff     <= rsp_drop_in;
      rsp_mark_ff     <= rsp_mark_in;
      rsp_nonempty_ff <= rsp_nonempty_in;
   end

   assign busy               = busy_ff;
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_seg_out        = rsp_seg_ff;
   assign rsp_time_out       = rsp_time_ff;
   assign rsp_opening_out    = rsp_open_ff;
   assign rsp_dropped        = rsp_drop_ff;
   assign rsp_mark_out       = rsp_mark_ff;
   assign rsp_table_nonempty = rsp_nonempty_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count exceeds table depth");

   a_one_query: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid))
      else $error("more than one lookup in the cell row");

   a_query_while_busy: assert property (@(posedge clock) disable iff (reset)
      tail_tok.valid |-> busy_ff)
      else $error("lookup leaves the cell row while the block is not busy");

   a_lookup_holds_off: assert property (@(posedge clock) disable iff (reset)
      (accept && is_lookup) |=> (busy_ff && !rsp_strobe_ff))
      else $error("lookup did not hold the block busy");

endmodule

`default_nettype wire

>>> src/sbt_cell.sv
`default_nettype none

module sbt_cell
   import sbt_pkg::*;
#(
   parameter int DEPTH = SBT_DEPTH,
   parameter int IDX   = 0,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             shift_i,
   input  wire entry_type        entry_i,
   output      entry_type        entry_o,
   input  wire logic [CNT_W-1:0] count_i,
   input  wire token_type        tok_i,
   output      token_type        tok_o
);

   entry_type entry_ff;
   token_type tok_ff;
   token_type tok_in;
   logic      live;
   logic      hit_a;
   logic      cond_b;
   logic      hit_b;

   // Cells are ordered by age, so cell IDX is live when it lies below the fill count.
   assign live = CNT_W'(IDX) < count_i;

   always_comb begin
      hit_a = live && tok_i.valid &&
              (tok_i.op == OP_AT_OR_BEF || tok_i.op == OP_ANCHOR) &&
              ($signed(entry_ff.stamp) <= $signed(tok_i.key_time));
      case (tok_i.op)
         OP_EXACT:      cond_b = $signed(entry_ff.seg) == $signed(tok_i.key_seg);
         OP_AFTER_NUM:  cond_b = $signed(entry_ff.seg) > $signed(tok_i.key_seg);
         OP_AFTER_TIME,
         OP_ANCHOR:     cond_b = $signed(entry_ff.stamp) > $signed(tok_i.key_time);
         default:       cond_b = 1'b0;
      endcase
      hit_b = live && tok_i.valid && cond_b;

      tok_in = tok_i;
      if (hit_a && !tok_i.a_hit) begin
         tok_in.a_hit = 1'b1;
         tok_in.a     = entry_ff;
      end
      // Later cells are older, so a later match replaces an earlier one.
      if (hit_b) begin
         tok_in.b_hit = 1'b1;
         tok_in.b     = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_i) begin
         entry_ff <= entry_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign entry_o = entry_ff;
   assign tok_o   = tok_ff;

endmodule

`default_nettype wire
